[sv/buffer_status_report_codec_top_defines.svh]
// Assertion macros for the buffer status report codec.
// Included by the top level; relies on clk and arst_n in the including scope.
`ifndef BUFFER_STATUS_REPORT_CODEC_TOP_DEFINES_SVH
`define BUFFER_STATUS_REPORT_CODEC_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define BSR_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bsr assertion failed");
`define BSR_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bsr assertion failed");
`else
`define BSR_ASSERT_NOW(lbl, ante, cons)
`define BSR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

[sv/bsr_pkg.sv]
// Types and constants of the buffer status report codec.
// Holds the level upper-bound table; no dependencies.
package bsr_pkg;

	localparam int NumGroups = 4;
	localparam int NumLevels = 64;
	localparam int LastLevel = 62;
	localparam int TableTop  = 61;

	typedef logic [5:0]  lvl_t;
	typedef logic [1:0]  grp_t;
	typedef logic [17:0] size_t;
	typedef logic [31:0] bytes_t;

	typedef enum logic {
		REQ_ENCODE = 1'b0,
		REQ_DECODE = 1'b1
	} req_t;

	localparam grp_t  LEN_LONG  = 2'd3;
	localparam grp_t  LEN_SHORT = 2'd1;
	localparam lvl_t  TOP_LEVEL = 6'd63;
	localparam size_t MAX_SIZE  = 18'd150000;

	localparam size_t LEVEL_UPPER [NumLevels] = '{
		18'd0,      18'd10,     18'd12,     18'd14,     18'd17,     18'd19,
		18'd22,     18'd26,     18'd31,     18'd36,     18'd42,     18'd49,
		18'd57,     18'd67,     18'd78,     18'd91,     18'd107,    18'd125,
		18'd146,    18'd171,    18'd200,    18'd234,    18'd274,    18'd321,
		18'd376,    18'd440,    18'd515,    18'd603,    18'd706,    18'd826,
		18'd967,    18'd1132,   18'd1326,   18'd1552,   18'd1817,   18'd2127,
		18'd2490,   18'd2915,   18'd3413,   18'd3995,   18'd4677,   18'd5476,
		18'd6411,   18'd7505,   18'd8787,   18'd10287,  18'd12043,  18'd14099,
		18'd16507,  18'd19325,  18'd22624,  18'd26487,  18'd31009,  18'd36304,
		18'd42502,  18'd49759,  18'd58255,  18'd68201,  18'd79846,  18'd93479,
		18'd109439, 18'd128125, 18'd150000, 18'd150000
	};

endpackage

[sv/buffer_status_report_codec_top.sv]
// Buffer status report codec: three registered stages from input to result.
// Throughput one beat per cycle when not stalled; stage 1 compares sizes to the
// level table, stage 2 encodes/unpacks levels, stage 3 packs bytes or looks up
// sizes. Stall of the output holds only the stages that are full.
// Reset (arst_n low) clears the stage valid bits; data registers are not reset.
`include "buffer_status_report_codec_top_defines.svh"

module buffer_status_report_codec_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic               long_format,
	input  bsr_pkg::bytes_t    group_size_0,
	input  bsr_pkg::bytes_t    group_size_1,
	input  bsr_pkg::bytes_t    group_size_2,
	input  bsr_pkg::bytes_t    group_size_3,
	input  logic [7:0]         report_byte_0,
	input  logic [7:0]         report_byte_1,
	input  logic [7:0]         report_byte_2,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         packed_byte_0,
	output logic [7:0]         packed_byte_1,
	output logic [7:0]         packed_byte_2,
	output bsr_pkg::grp_t      packed_length,
	output bsr_pkg::grp_t      group_index,
	output bsr_pkg::size_t     decoded_size_0,
	output bsr_pkg::size_t     decoded_size_1,
	output bsr_pkg::size_t     decoded_size_2,
	output bsr_pkg::size_t     decoded_size_3
);
	import bsr_pkg::*;

	logic adv1, adv2, adv3;
	logic v_s1, v_s2, v_s3;

	bytes_t              size_in [NumGroups];
	logic [TableTop:1]   le_d    [NumGroups];
	logic [NumGroups-1:0] zero_d, over_d;

	logic                req_s1, long_s1;
	logic [TableTop:1]   le_s1   [NumGroups];
	logic [NumGroups-1:0] zero_s1, over_s1;
	logic [7:0]          b0_s1, b1_s1, b2_s1;

	logic [LastLevel:0]  ext;
	lvl_t                lv_d    [NumGroups];
	grp_t                grp_d;
	lvl_t                lv_s2   [NumGroups];
	grp_t                grp_s2;
	logic                req_s2, long_s2;

	logic [7:0]          pb0_d, pb1_d, pb2_d;
	grp_t                gi_d;
	size_t               ds_d    [NumGroups];
	logic [7:0]          pb0_s3, pb1_s3, pb2_s3;
	grp_t                len_s3, gi_s3;
	size_t               ds_s3   [NumGroups];

	assign adv3     = !v_s3 || !out_stall;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign in_stall = !adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	assign size_in[0] = group_size_0;
	assign size_in[1] = group_size_1;
	assign size_in[2] = group_size_2;
	assign size_in[3] = group_size_3;

	always_comb begin
		for (int g = 0; g < NumGroups; g++) begin
			zero_d[g] = (size_in[g] == '0);
			over_d[g] = (size_in[g] > {14'd0, MAX_SIZE});
			for (int k = 1; k <= TableTop; k++) begin
				le_d[g][k] = (size_in[g] <= {14'd0, LEVEL_UPPER[k]});
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			req_s1  <= req_type;
			long_s1 <= long_format;
			le_s1   <= le_d;
			zero_s1 <= zero_d;
			over_s1 <= over_d;
			b0_s1   <= report_byte_0;
			b1_s1   <= report_byte_1;
			b2_s1   <= report_byte_2;
		end
	end

	always_comb begin
		ext   = '0;
		grp_d = '0;
		for (int g = 0; g < NumGroups; g++) lv_d[g] = '0;
		if (req_s1 == REQ_DECODE) begin
			if (long_s1) begin
				lv_d[0] = b0_s1[7:2];
				lv_d[1] = {b0_s1[1:0], b1_s1[7:4]};
				lv_d[2] = {b1_s1[3:0], b2_s1[7:6]};
				lv_d[3] = b2_s1[5:0];
			end else begin
				grp_d       = b0_s1[7:6];
				lv_d[grp_d] = b0_s1[5:0];
			end
		end else begin
			for (int g = 0; g < NumGroups; g++) begin
				ext = {1'b1, le_s1[g], 1'b0};
				for (int k = 1; k <= LastLevel; k++) begin
					if (ext[k] && !ext[k-1]) lv_d[g] = lv_d[g] | lvl_t'(k);
				end
				if (zero_s1[g]) lv_d[g] = '0;
				else if (over_s1[g]) lv_d[g] = TOP_LEVEL;
				if (!zero_s1[g]) grp_d = grp_t'(g);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			lv_s2   <= lv_d;
			grp_s2  <= grp_d;
			req_s2  <= req_s1;
			long_s2 <= long_s1;
		end
	end

	always_comb begin
		pb0_d = '0;
		pb1_d = '0;
		pb2_d = '0;
		gi_d  = long_s2 ? '0 : grp_s2;
		for (int g = 0; g < NumGroups; g++) ds_d[g] = '0;
		if (req_s2 == REQ_DECODE) begin
			for (int g = 0; g < NumGroups; g++) ds_d[g] = LEVEL_UPPER[lv_s2[g]];
		end else if (long_s2) begin
			pb0_d = {lv_s2[0], lv_s2[1][5:4]};
			pb1_d = {lv_s2[1][3:0], lv_s2[2][5:2]};
			pb2_d = {lv_s2[2][1:0], lv_s2[3]};
		end else begin
			pb0_d = {grp_s2, lv_s2[grp_s2]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv3) begin
			pb0_s3 <= pb0_d;
			pb1_s3 <= pb1_d;
			pb2_s3 <= pb2_d;
			len_s3 <= long_s2 ? LEN_LONG : LEN_SHORT;
			gi_s3  <= gi_d;
			ds_s3  <= ds_d;
		end
	end

	assign out_valid      = v_s3;
	assign packed_byte_0  = pb0_s3;
	assign packed_byte_1  = pb1_s3;
	assign packed_byte_2  = pb2_s3;
	assign packed_length  = len_s3;
	assign group_index    = gi_s3;
	assign decoded_size_0 = ds_s3[0];
	assign decoded_size_1 = ds_s3[1];
	assign decoded_size_2 = ds_s3[2];
	assign decoded_size_3 = ds_s3[3];

	`BSR_ASSERT_NOW(a_stall_only_full, in_stall, v_s1 && v_s2 && v_s3)
	`BSR_ASSERT_NOW(a_short_tail_zero, out_valid && packed_length == LEN_SHORT,
		packed_byte_1 == 8'd0 && packed_byte_2 == 8'd0)
	`BSR_ASSERT_NOW(a_long_group_zero, out_valid && packed_length == LEN_LONG,
		group_index == 2'd0)
	`BSR_ASSERT_NOW(a_decode_no_bytes,
		out_valid && (decoded_size_0 != '0 || decoded_size_1 != '0 ||
		decoded_size_2 != '0 || decoded_size_3 != '0),
		packed_byte_0 == 8'd0)
	`BSR_ASSERT_NEXT(a_hold_on_stall, v_s3 && out_stall, v_s3 && $stable(pb0_s3))

endmodule
